### design/dam_pkg.sv
// ----------------------------------------------------------------------------
// dam_pkg
// Shared constants, codes, command/status types and helpers for the decimal
// accumulator machine.
// ----------------------------------------------------------------------------
package dam_pkg;

   localparam int DEF_MEMORY_WORDS = 10000;
   localparam int DEF_WORD_LIMIT   = 999999;

   localparam int ADDR_W = 14;
   localparam int WORD_W = 21;
   localparam int MAG_W  = 20;
   localparam int OP_W   = 7;
   localparam int STAT_W = 3;
   localparam int RES_W  = 2 * WORD_W;
   localparam int CNT_W  = $clog2(MAG_W);

   localparam int SPLIT_BASE  = 10000;
   localparam int SPLIT_SHIFT = 34;
   localparam int PROD_W      = MAG_W + WORD_W;
   localparam logic [WORD_W-1:0] SPLIT_MUL = 21'd1717987;

   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_HALT     = 3'd1;
   localparam logic [STAT_W-1:0] ST_DIVZERO  = 3'd2;
   localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd3;
   localparam logic [STAT_W-1:0] ST_BADOP    = 3'd4;
   localparam logic [STAT_W-1:0] ST_REJECT   = 3'd5;

   localparam logic [OP_W-1:0] OP_READ  = 7'd10;
   localparam logic [OP_W-1:0] OP_WRITE = 7'd11;
   localparam logic [OP_W-1:0] OP_LOAD  = 7'd20;
   localparam logic [OP_W-1:0] OP_STORE = 7'd21;
   localparam logic [OP_W-1:0] OP_ADD   = 7'd30;
   localparam logic [OP_W-1:0] OP_SUB   = 7'd31;
   localparam logic [OP_W-1:0] OP_DIV   = 7'd32;
   localparam logic [OP_W-1:0] OP_MUL   = 7'd33;
   localparam logic [OP_W-1:0] OP_MOD   = 7'd34;
   localparam logic [OP_W-1:0] OP_POW   = 7'd35;
   localparam logic [OP_W-1:0] OP_JMP   = 7'd40;
   localparam logic [OP_W-1:0] OP_JNEG  = 7'd41;
   localparam logic [OP_W-1:0] OP_JZERO = 7'd42;
   localparam logic [OP_W-1:0] OP_HALT  = 7'd43;

   typedef struct packed {
      logic capture;
      logic clear;
      logic fetch;
      logic split;
      logic decode;
      logic read_opnd;
      logic latch_m;
      logic exec;
      logic div_step;
      logic div_fix;
      logic pow_mul;
      logic pow_chk;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic step_go;
      logic clr_last;
      logic cls_div;
      logic cls_pow;
      logic pow_more;
      logic div_last;
      logic out_free;
   } dp_sts_type;

   function automatic logic op_known(input logic [OP_W-1:0] op);
      logic known;
      unique case (op)
         OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_DIV,
         OP_MUL, OP_MOD, OP_POW, OP_JMP, OP_JNEG, OP_JZERO, OP_HALT: known = 1'b1;
         default: known = 1'b0;
      endcase
      return known;
   endfunction

   function automatic logic beyond_limit(input logic signed [RES_W-1:0] v,
                                         input logic signed [RES_W-1:0] lim);
      return (v > lim) || (v < -lim);
   endfunction

endpackage

### design/dam_ram.sv
// ----------------------------------------------------------------------------
// dam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dam_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 10000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/dam_ctrl.sv
// ----------------------------------------------------------------------------
// dam_ctrl
// Sequencer: clear sweep, fetch/decode/execute steps, iterative divide and
// power loops, and result commit.
// ----------------------------------------------------------------------------
module dam_ctrl
   import dam_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_FETCH   = 4'd2;
   localparam logic [3:0] S_SPLIT   = 4'd3;
   localparam logic [3:0] S_DECODE  = 4'd4;
   localparam logic [3:0] S_READM   = 4'd5;
   localparam logic [3:0] S_LATCH   = 4'd6;
   localparam logic [3:0] S_EXEC    = 4'd7;
   localparam logic [3:0] S_DIV     = 4'd8;
   localparam logic [3:0] S_DIVFIX  = 4'd9;
   localparam logic [3:0] S_POWTEST = 4'd10;
   localparam logic [3:0] S_POWMUL  = 4'd11;
   localparam logic [3:0] S_POWCHK  = 4'd12;
   localparam logic [3:0] S_COMMIT  = 4'd13;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = sts.step_go ? S_FETCH : S_COMMIT;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_SPLIT;
         end
         S_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = S_DECODE;
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = S_READM;
         end
         S_READM: begin
            cmd.read_opnd = 1'b1;
            state_in      = S_LATCH;
         end
         S_LATCH: begin
            cmd.latch_m = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            priority if (sts.cls_div) begin
               state_in = S_DIV;
            end else if (sts.cls_pow) begin
               state_in = S_POWTEST;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_DIVFIX;
            end
         end
         S_DIVFIX: begin
            cmd.div_fix = 1'b1;
            state_in    = S_COMMIT;
         end
         S_POWTEST: begin
            state_in = sts.pow_more ? S_POWMUL : S_COMMIT;
         end
         S_POWMUL: begin
            cmd.pow_mul = 1'b1;
            state_in    = S_POWCHK;
         end
         S_POWCHK: begin
            cmd.pow_chk = 1'b1;
            state_in    = S_POWTEST;
         end
         S_COMMIT: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

### design/dam_datapath.sv
// ----------------------------------------------------------------------------
// dam_datapath
// Machine state, main memory, word split, ALU, iterative divider, power
// loop and the registered response.
// ----------------------------------------------------------------------------
module dam_datapath
   import dam_pkg::*;
#(
   parameter int MEMORY_WORDS = DEF_MEMORY_WORDS,
   parameter int WORD_LIMIT   = DEF_WORD_LIMIT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_sts_type               sts,
   input  logic                     req_operation,
   input  logic [ADDR_W-1:0]        req_address,
   input  logic signed [WORD_W-1:0] req_data_word,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STAT_W-1:0]        rsp_status,
   output logic                     rsp_out_valid,
   output logic [ADDR_W-1:0]        rsp_out_address,
   output logic signed [WORD_W-1:0] rsp_out_value,
   output logic [ADDR_W-1:0]        rsp_program_count,
   output logic signed [WORD_W-1:0] rsp_accumulator_value
);

   localparam int AW = $clog2(MEMORY_WORDS);
   localparam logic [ADDR_W-1:0] MEM_END = ADDR_W'(MEMORY_WORDS);
   localparam logic signed [RES_W-1:0] LIM = RES_W'(WORD_LIMIT);

   logic                     req_op_ff, req_op_in;
   logic [ADDR_W-1:0]        req_addr_ff, req_addr_in;
   logic signed [WORD_W-1:0] req_data_ff, req_data_in;
   logic signed [WORD_W-1:0] acc_ff, acc_in;
   logic [ADDR_W-1:0]        pc_ff, pc_in;
   logic [STAT_W-1:0]        run_ff, run_in;
   logic [AW-1:0]            clr_ff, clr_in;
   logic signed [WORD_W-1:0] word_ff, word_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [OP_W-1:0]          opcode_ff, opcode_in;
   logic [ADDR_W-1:0]        opnd_ff, opnd_in;
   logic signed [WORD_W-1:0] m_ff, m_in;
   logic signed [RES_W-1:0]  res_ff, res_in;
   logic signed [RES_W-1:0]  mul_ff, mul_in;
   logic [STAT_W-1:0]        fault_ff, fault_in;
   logic [MAG_W-1:0]         exp_ff, exp_in;
   logic [MAG_W-1:0]         rem_ff, rem_in;
   logic [MAG_W-1:0]         dvd_ff, dvd_in;
   logic [MAG_W-1:0]         dvs_ff, dvs_in;
   logic [CNT_W-1:0]         dcnt_ff, dcnt_in;
   logic                     qneg_ff, qneg_in;
   logic                     rneg_ff, rneg_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic                     rsp_out_valid_ff, rsp_out_valid_in;
   logic [ADDR_W-1:0]        rsp_out_address_ff, rsp_out_address_in;
   logic signed [WORD_W-1:0] rsp_out_value_ff, rsp_out_value_in;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [WORD_W-1:0]        wr_data;
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;
   logic [WORD_W-1:0]        rd_data;

   logic                     out_free;
   logic                     pc_oob;
   logic                     opnd_in_range;
   logic                     addr_in_range;
   logic [ADDR_W-1:0]        pc_plus;
   logic [ADDR_W-1:0]        pc_next;
   logic signed [WORD_W-1:0] fetch_word;
   logic [OP_W-1:0]          op_q;
   logic [MAG_W-1:0]         acc_mag;
   logic [MAG_W-1:0]         m_mag;
   logic [MAG_W:0]           div_sh;
   logic [MAG_W:0]           div_diff;
   logic                     div_ge;
   logic signed [RES_W-1:0]  q_ext;
   logic signed [RES_W-1:0]  r_ext;
   logic                     data_rej;
   logic [STAT_W-1:0]        fin_fault;
   logic                     advance;

   dam_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEMORY_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign pc_oob        = !(pc_ff < MEM_END);
   assign opnd_in_range = (opnd_ff < MEM_END);
   assign addr_in_range = (req_addr_ff < MEM_END);
   assign pc_plus       = pc_ff + ADDR_W'(1);
   assign pc_next       = (pc_plus < MEM_END) ? pc_plus : '0;
   assign fetch_word    = pc_oob ? '0 : $signed(rd_data);
   assign op_q          = prod_ff[SPLIT_SHIFT+OP_W-1:SPLIT_SHIFT];
   assign acc_mag       = acc_ff[WORD_W-1] ? MAG_W'(-acc_ff) : acc_ff[MAG_W-1:0];
   assign m_mag         = m_ff[WORD_W-1] ? MAG_W'(-m_ff) : m_ff[MAG_W-1:0];
   assign div_sh        = {rem_ff, dvd_ff[MAG_W-1]};
   assign div_diff      = div_sh - {1'b0, dvs_ff};
   assign div_ge        = (div_sh >= {1'b0, dvs_ff});
   assign q_ext         = $signed({{(RES_W-MAG_W){1'b0}}, dvd_ff});
   assign r_ext         = $signed({{(RES_W-MAG_W){1'b0}}, rem_ff});
   assign data_rej      = beyond_limit(RES_W'(req_data_ff), LIM);
   assign fin_fault     = (fault_ff != ST_OK) ? fault_ff :
                          (beyond_limit(res_ff, LIM) ? ST_OVERFLOW : ST_OK);

   assign rd_en   = cmd.fetch || cmd.read_opnd;
   assign rd_addr = cmd.fetch ? pc_ff[AW-1:0] : opnd_ff[AW-1:0];

   always_comb begin
      req_op_in          = req_op_ff;
      req_addr_in        = req_addr_ff;
      req_data_in        = req_data_ff;
      acc_in             = acc_ff;
      pc_in              = pc_ff;
      run_in             = run_ff;
      clr_in             = clr_ff;
      word_in            = word_ff;
      prod_in            = prod_ff;
      opcode_in          = opcode_ff;
      opnd_in            = opnd_ff;
      m_in               = m_ff;
      res_in             = res_ff;
      mul_in             = mul_ff;
      fault_in           = fault_ff;
      exp_in             = exp_ff;
      rem_in             = rem_ff;
      dvd_in             = dvd_ff;
      dvs_in             = dvs_ff;
      dcnt_in            = dcnt_ff;
      qneg_in            = qneg_ff;
      rneg_in            = rneg_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_status_in      = rsp_status_ff;
      rsp_out_valid_in   = rsp_out_valid_ff;
      rsp_out_address_in = rsp_out_address_ff;
      rsp_out_value_in   = rsp_out_value_ff;
      wr_en              = 1'b0;
      wr_addr            = clr_ff;
      wr_data            = '0;
      advance            = 1'b0;

      if (cmd.capture) begin
         req_op_in   = req_operation;
         req_addr_in = req_address;
         req_data_in = req_data_word;
      end

      if (cmd.clear) begin
         wr_en  = 1'b1;
         clr_in = clr_ff + AW'(1);
      end

      if (cmd.split) begin
         word_in = fetch_word;
         prod_in = PROD_W'(fetch_word[MAG_W-1:0]) * PROD_W'(SPLIT_MUL);
      end

      if (cmd.decode) begin
         opcode_in = word_ff[WORD_W-1] ? '0 : op_q;
         opnd_in   = ADDR_W'(word_ff[MAG_W-1:0] - MAG_W'(op_q) * MAG_W'(SPLIT_BASE));
      end

      if (cmd.latch_m) begin
         m_in = opnd_in_range ? $signed(rd_data) : '0;
      end

      if (cmd.exec) begin
         fault_in = ST_OK;
         exp_in   = '0;
         res_in   = RES_W'(acc_ff);
         dvd_in   = acc_mag;
         dvs_in   = m_mag;
         rem_in   = '0;
         dcnt_in  = '0;
         qneg_in  = acc_ff[WORD_W-1] ^ m_ff[WORD_W-1];
         rneg_in  = acc_ff[WORD_W-1];
         if (!op_known(opcode_ff)) begin
            fault_in = ST_BADOP;
         end else begin
            unique case (opcode_ff)
               OP_LOAD:  res_in = RES_W'(m_ff);
               OP_STORE: res_in = '0;
               OP_ADD:   res_in = RES_W'(acc_ff) + RES_W'(m_ff);
               OP_SUB:   res_in = RES_W'(acc_ff) - RES_W'(m_ff);
               OP_MUL:   res_in = RES_W'(acc_ff) * RES_W'(m_ff);
               OP_DIV, OP_MOD: begin
                  if (m_ff == '0) begin
                     fault_in = ST_DIVZERO;
                  end
               end
               OP_POW: begin
                  priority if (m_ff == '0) begin
                     res_in = RES_W'(1);
                  end else if (acc_ff == WORD_W'(1)) begin
                     res_in = RES_W'(1);
                  end else if (acc_ff == -WORD_W'(1)) begin
                     res_in = m_ff[0] ? -RES_W'(1) : RES_W'(1);
                  end else if (acc_ff == '0) begin
                     res_in = '0;
                     if (m_ff[WORD_W-1]) begin
                        fault_in = ST_DIVZERO;
                     end
                  end else if (m_ff[WORD_W-1]) begin
                     res_in = '0;
                  end else begin
                     exp_in = m_ff[MAG_W-1:0] - MAG_W'(1);
                  end
               end
               default: ;
            endcase
         end
      end

      if (cmd.div_step) begin
         rem_in  = div_ge ? div_diff[MAG_W-1:0] : div_sh[MAG_W-1:0];
         dvd_in  = {dvd_ff[MAG_W-2:0], div_ge};
         dcnt_in = dcnt_ff + CNT_W'(1);
      end

      if (cmd.div_fix) begin
         if (opcode_ff == OP_DIV) begin
            res_in = qneg_ff ? -q_ext : q_ext;
         end else begin
            res_in = rneg_ff ? -r_ext : r_ext;
         end
      end

      if (cmd.pow_mul) begin
         mul_in = RES_W'($signed(res_ff[WORD_W-1:0])) * RES_W'(acc_ff);
      end

      if (cmd.pow_chk) begin
         if (beyond_limit(mul_ff, LIM)) begin
            fault_in = ST_OVERFLOW;
            exp_in   = '0;
         end else begin
            res_in = mul_ff;
            exp_in = exp_ff - MAG_W'(1);
         end
      end

      if (cmd.commit) begin
         rsp_valid_in       = 1'b1;
         rsp_status_in      = run_ff;
         rsp_out_valid_in   = 1'b0;
         rsp_out_address_in = '0;
         rsp_out_value_in   = '0;
         priority if (!req_op_ff) begin
            if (data_rej) begin
               rsp_status_in = ST_REJECT;
            end else if (addr_in_range) begin
               wr_en   = 1'b1;
               wr_addr = req_addr_ff[AW-1:0];
               wr_data = req_data_ff;
            end
         end else if (run_ff != ST_OK) begin
            rsp_status_in = run_ff;
         end else if (fin_fault != ST_OK) begin
            run_in        = fin_fault;
            rsp_status_in = fin_fault;
         end else begin
            acc_in  = res_ff[WORD_W-1:0];
            advance = 1'b1;
            unique case (opcode_ff)
               OP_READ: begin
                  if (data_rej) begin
                     rsp_status_in = ST_REJECT;
                     advance       = 1'b0;
                  end else if (opnd_in_range) begin
                     wr_en   = 1'b1;
                     wr_addr = opnd_ff[AW-1:0];
                     wr_data = req_data_ff;
                  end
               end
               OP_WRITE: begin
                  rsp_out_valid_in   = 1'b1;
                  rsp_out_address_in = opnd_ff;
                  rsp_out_value_in   = m_ff;
               end
               OP_STORE: begin
                  if (opnd_in_range) begin
                     wr_en   = 1'b1;
                     wr_addr = opnd_ff[AW-1:0];
                     wr_data = acc_ff;
                  end
               end
               OP_JMP: begin
                  pc_in   = opnd_ff;
                  advance = 1'b0;
               end
               OP_JNEG: begin
                  if (acc_ff[WORD_W-1]) begin
                     pc_in   = opnd_ff;
                     advance = 1'b0;
                  end
               end
               OP_JZERO: begin
                  if (acc_ff == '0) begin
                     pc_in   = opnd_ff;
                     advance = 1'b0;
                  end
               end
               OP_HALT: begin
                  run_in        = ST_HALT;
                  rsp_status_in = ST_HALT;
                  advance       = 1'b0;
               end
               default: ;
            endcase
            if (advance) begin
               pc_in = pc_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pc_ff        <= '0;
         run_ff       <= ST_OK;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         pc_ff        <= pc_in;
         run_ff       <= run_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_op_ff          <= req_op_in;
      req_addr_ff        <= req_addr_in;
      req_data_ff        <= req_data_in;
      word_ff            <= word_in;
      prod_ff            <= prod_in;
      opcode_ff          <= opcode_in;
      opnd_ff            <= opnd_in;
      m_ff               <= m_in;
      res_ff             <= res_in;
      mul_ff             <= mul_in;
      fault_ff           <= fault_in;
      exp_ff             <= exp_in;
      rem_ff             <= rem_in;
      dvd_ff             <= dvd_in;
      dvs_ff             <= dvs_in;
      dcnt_ff            <= dcnt_in;
      qneg_ff            <= qneg_in;
      rneg_ff            <= rneg_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_out_valid_ff   <= rsp_out_valid_in;
      rsp_out_address_ff <= rsp_out_address_in;
      rsp_out_value_ff   <= rsp_out_value_in;
   end

   assign sts.step_go  = req_operation && (run_ff == ST_OK);
   assign sts.clr_last = (clr_ff == AW'(MEMORY_WORDS - 1));
   assign sts.cls_div  = (opcode_ff == OP_DIV) || (opcode_ff == OP_MOD);
   assign sts.cls_pow  = (opcode_ff == OP_POW);
   assign sts.pow_more = (exp_ff != '0);
   assign sts.div_last = (dcnt_ff == CNT_W'(MAG_W - 1));
   assign sts.out_free = out_free;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_out_valid         = rsp_out_valid_ff;
   assign rsp_out_address       = rsp_out_address_ff;
   assign rsp_out_value         = rsp_out_value_ff;
   assign rsp_program_count     = pc_ff;
   assign rsp_accumulator_value = acc_ff;

   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      (run_ff != ST_OK) |=> (run_ff == $past(run_ff)))
      else $error("run status left a stopped state");

   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_out_valid_ff) |-> (rsp_status_ff == ST_OK))
      else $error("output value shown with a non-ok status");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> out_free)
      else $error("commit while response register is occupied");

   a_commit_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not raise response valid");

endmodule

### design/decimal_accumulator_machine.sv
// ----------------------------------------------------------------------------
// decimal_accumulator_machine
// Decimal-word accumulator machine with a cleared main memory.
//
// Requests arrive on req_* (valid/ready). req_operation 0 loads req_data_word
// into memory at req_address; 1 executes the instruction at the program
// counter, with req_data_word as the value taken in by a READ instruction.
// Every request produces exactly one response on rsp_* (valid/ready) with
// the status, any WRITE output, and program counter and accumulator after.
// After reset the block sweeps the main memory to zero, one word per cycle,
// before req_ready rises.
// One request is in flight at a time. A load goes from accept straight to
// commit; so does a step that is not taken (machine stopped). An executed
// step runs through fetch, split, decode, operand read, latch and execute,
// then divide or mod (one quotient bit per cycle), or a power loop of test,
// multiply and check (at most about 20 multiplies before overflow).
// The response sits in an output register; while the receiver stalls, the
// block finishes the next request up to commit and holds there.
// ----------------------------------------------------------------------------
module decimal_accumulator_machine
   import dam_pkg::*;
#(
   parameter int MEMORY_WORDS = DEF_MEMORY_WORDS,
   parameter int WORD_LIMIT   = DEF_WORD_LIMIT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_operation,
   input  logic [ADDR_W-1:0]        req_address,
   input  logic signed [WORD_W-1:0] req_data_word,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STAT_W-1:0]        rsp_status,
   output logic                     rsp_out_valid,
   output logic [ADDR_W-1:0]        rsp_out_address,
   output logic signed [WORD_W-1:0] rsp_out_value,
   output logic [ADDR_W-1:0]        rsp_program_count,
   output logic signed [WORD_W-1:0] rsp_accumulator_value
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   dam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dam_datapath #(
      .MEMORY_WORDS (MEMORY_WORDS),
      .WORD_LIMIT   (WORD_LIMIT)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_operation         (req_operation),
      .req_address           (req_address),
      .req_data_word         (req_data_word),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_out_valid         (rsp_out_valid),
      .rsp_out_address       (rsp_out_address),
      .rsp_out_value         (rsp_out_value),
      .rsp_program_count     (rsp_program_count),
      .rsp_accumulator_value (rsp_accumulator_value)
   );

endmodule

### tb/sv/decimal_accumulator_machine_test.sv
// ----------------------------------------------------------------------------
// decimal_accumulator_machine_test
// Runs small programs on the decimal accumulator machine: each instruction is
// loaded at the program counter together with its operand word, then
// stepped. A behavioral copy of the machine predicts every response, and the
// responses are compared field by field in arrival order. Both sides of the
// handshake stall at random. The run ends on one sticky stop condition,
// after which loads and steps against the stopped machine follow.
// ----------------------------------------------------------------------------
module decimal_accumulator_machine_test;
   import dam_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MEM_WORDS  = DEF_MEMORY_WORDS;
   localparam int LIMIT      = DEF_WORD_LIMIT;
   localparam int ITEM_GOAL  = 2000;
   localparam int STALL_MAX  = 30000;

   typedef struct {
      bit                       drain;
      bit                       calm;
      logic                     operation;
      logic [ADDR_W-1:0]        address;
      logic signed [WORD_W-1:0] data_word;
   } request_type;

   typedef struct {
      logic [STAT_W-1:0]        status;
      logic                     out_valid;
      logic [ADDR_W-1:0]        out_address;
      logic signed [WORD_W-1:0] out_value;
      logic [ADDR_W-1:0]        program_count;
      logic signed [WORD_W-1:0] accumulator_value;
   } response_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_operation = 1'b0;
   logic [ADDR_W-1:0]        req_address = '0;
   logic signed [WORD_W-1:0] req_data_word = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STAT_W-1:0]        rsp_status;
   logic                     rsp_out_valid;
   logic [ADDR_W-1:0]        rsp_out_address;
   logic signed [WORD_W-1:0] rsp_out_value;
   logic [ADDR_W-1:0]        rsp_program_count;
   logic signed [WORD_W-1:0] rsp_accumulator_value;

   request_type  request_q[$];
   response_type response_q[$];

   int  sent_count = 0;
   int  got_count = 0;
   int  mismatches = 0;
   int  send_gap = 0;
   int  take_gap = 0;
   int  long_hold = 0;
   bit  long_done = 0;
   bit  quiet = 0;
   int  idle_cycles = 0;
   bit  calm_now = 0;

   // machine copy used for prediction
   int          mem_word[MEM_WORDS];
   longint      acc_now;
   int          pc_now;
   logic [2:0]  run_state;

   logic [OP_W-1:0] safe_ops[13] = '{OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD,
                                     OP_SUB, OP_DIV, OP_MUL, OP_MOD, OP_POW, OP_JMP,
                                     OP_JNEG, OP_JZERO};

   decimal_accumulator_machine DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_address           (req_address),
      .req_data_word         (req_data_word),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_out_valid         (rsp_out_valid),
      .rsp_out_address       (rsp_out_address),
      .rsp_out_value         (rsp_out_value),
      .rsp_program_count     (rsp_program_count),
      .rsp_accumulator_value (rsp_accumulator_value)
   );

   always #5 clock = ~clock;

   function automatic longint magnitude(input longint v);
      return v < 0 ? -v : v;
   endfunction

   // arithmetic opcodes: fault code and new accumulator
   function automatic void arith(input int opc, input longint a, input longint b,
                                 output logic [2:0] fault, output longint r);
      longint ex;
      int     n;
      fault = ST_OK;
      r = a;
      case (opc)
         OP_ADD: r = a + b;
         OP_SUB: r = a - b;
         OP_MUL: r = a * b;
         OP_DIV: if (b == 0) fault = ST_DIVZERO; else r = a / b;
         OP_MOD: if (b == 0) fault = ST_DIVZERO; else r = a % b;
         OP_POW: begin
            ex = b;
            if (ex == 0 || a == 1) r = 1;
            else if (a == -1) r = (ex & 1) ? -1 : 1;
            else if (a == 0) begin
               if (ex < 0) fault = ST_DIVZERO;
               else r = 0;
            end else if (ex < 0) r = 0;
            else begin
               r = 1;
               for (n = 0; n < ex && fault == ST_OK; n++) begin
                  r = r * a;
                  if (magnitude(r) > LIMIT) fault = ST_OVERFLOW;
               end
            end
         end
         default: ;
      endcase
      if (fault == ST_OK && magnitude(r) > LIMIT) fault = ST_OVERFLOW;
   endfunction

   // queue one request and the response the machine must give for it
   task automatic issue(input bit op, input int addr, input int dw);
      request_type  rq;
      response_type rs;
      int           word, opc, opnd;
      longint       m, r;
      logic [2:0]   fault;
      bit           adv;
      rq.drain = 0;
      rq.calm = calm_now;
      rq.operation = op;
      rq.address = ADDR_W'(addr);
      rq.data_word = WORD_W'(dw);
      rs.status = run_state;
      rs.out_valid = 0;
      rs.out_address = '0;
      rs.out_value = '0;
      if (!op) begin
         if (magnitude(dw) > LIMIT) rs.status = ST_REJECT;
         else if (addr < MEM_WORDS) mem_word[addr] = dw;
      end else if (run_state == ST_OK) begin
         word = mem_word[pc_now];
         opc = word / SPLIT_BASE;
         opnd = word % SPLIT_BASE;
         m = (opnd >= 0) ? mem_word[opnd] : 0;
         r = acc_now;
         fault = ST_OK;
         adv = 1;
         case (opc)
            OP_READ: begin
               if (magnitude(dw) > LIMIT) begin
                  rs.status = ST_REJECT;
                  adv = 0;
               end else mem_word[opnd] = dw;
            end
            OP_WRITE: begin
               rs.out_valid = 1;
               rs.out_address = ADDR_W'(opnd);
               rs.out_value = WORD_W'(m);
            end
            OP_LOAD: r = m;
            OP_STORE: begin
               mem_word[opnd] = int'(acc_now);
               r = 0;
            end
            OP_ADD, OP_SUB, OP_DIV, OP_MUL, OP_MOD, OP_POW: arith(opc, acc_now, m, fault, r);
            OP_JMP: begin
               pc_now = opnd;
               adv = 0;
            end
            OP_JNEG: if (acc_now < 0) begin
               pc_now = opnd;
               adv = 0;
            end
            OP_JZERO: if (acc_now == 0) begin
               pc_now = opnd;
               adv = 0;
            end
            OP_HALT: begin
               run_state = ST_HALT;
               rs.status = ST_HALT;
               adv = 0;
            end
            default: fault = ST_BADOP;
         endcase
         if (fault != ST_OK) begin
            run_state = fault;
            rs.status = fault;
            rs.out_valid = 0;
            rs.out_address = '0;
            rs.out_value = '0;
         end else begin
            acc_now = r;
            if (adv) pc_now = (pc_now + 1) % MEM_WORDS;
         end
      end
      rs.program_count = ADDR_W'(pc_now);
      rs.accumulator_value = WORD_W'(acc_now);
      request_q.push_back(rq);
      response_q.push_back(rs);
   endtask

   task automatic hold_until_drained();
      request_type rq;
      rq = '{drain: 1, calm: 0, operation: 0, address: '0, data_word: '0};
      request_q.push_back(rq);
   endtask

   // place operand and instruction, then step
   task automatic run_instr(input int opc, input int opnd, input int mval, input int dw);
      issue(0, opnd, mval);
      issue(0, pc_now, opc * SPLIT_BASE + opnd);
      issue(1, $urandom_range(0, 16383), dw);
   endtask

   function automatic int pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 24) - 12;
         1: return $urandom_range(0, 1998) - 999;
         2: return $urandom_range(0, 2 * LIMIT) - LIMIT;
         default: return 0;
      endcase
   endfunction

   task automatic random_instr();
      int          opc, opnd, mval, dw;
      longint      r;
      logic [2:0]  fault;
      logic signed [WORD_W-1:0] raw;
      do begin
         opc = safe_ops[$urandom_range(0, 12)];
         opnd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MEM_WORDS - 1)
                                            : $urandom_range(0, 63);
         if (opnd == pc_now) opnd = (opnd + 1) % MEM_WORDS;
         mval = pick_value();
         fault = ST_OK;
         if (opc inside {OP_ADD, OP_SUB, OP_DIV, OP_MUL, OP_MOD, OP_POW})
            arith(opc, acc_now, mval, fault, r);
      end while (fault != ST_OK);
      raw = WORD_W'($urandom);
      dw = ($urandom_range(0, 7) == 0) ? int'(raw) : pick_value();
      run_instr(opc, opnd, mval, dw);
   endtask

   task automatic random_noise();
      logic signed [WORD_W-1:0] raw;
      int addr;
      raw = WORD_W'($urandom);
      addr = $urandom_range(0, 16383);
      if (addr == pc_now) addr = 16383;
      issue(0, addr, raw);
   endtask

   task automatic stop_machine();
      case ($urandom_range(0, 3))
         0: run_instr(OP_HALT, $urandom_range(0, 9999), 0, 0);
         1: run_instr(($urandom_range(0, 1) ? OP_DIV : OP_MOD), 200, 0, 0);
         2: begin
            run_instr(OP_LOAD, 201, LIMIT, 0);
            run_instr(OP_ADD, 202, $urandom_range(1, LIMIT), 0);
         end
         default: begin
            issue(0, pc_now, -(int'(OP_ADD) * SPLIT_BASE + 5));
            issue(1, 0, 0);
         end
      endcase
   endtask

   task automatic build_stimulus();
      int n;
      for (n = 0; n < MEM_WORDS; n++) mem_word[n] = 0;
      acc_now = 0;
      pc_now = 0;
      run_state = ST_OK;
      issue(0, 16383, 5);
      issue(0, 9999, -LIMIT);
      issue(0, 1, LIMIT + 1);
      issue(0, 2, -1048576);
      issue(0, 3, 1048575);
      run_instr(OP_LOAD, 100, -1, 0);
      run_instr(OP_POW, 101, -7, 0);
      run_instr(OP_JNEG, 9999, 0, 0);
      run_instr(OP_ADD, 102, 0, 0);
      run_instr(OP_POW, 103, 0, 0);
      run_instr(OP_POW, 104, -3, 0);
      run_instr(OP_LOAD, 105, LIMIT, 0);
      run_instr(OP_POW, 106, -2, 0);
      run_instr(OP_WRITE, 9999, -LIMIT, 0);
      run_instr(OP_READ, 107, 0, 1048575);
      issue(1, 0, -LIMIT);
      run_instr(OP_STORE, 108, 0, 0);
      run_instr(OP_POW, 109, 5, 0);
      run_instr(OP_JZERO, 50, 0, 0);
      hold_until_drained();
      n = 0;
      while (request_q.size() < ITEM_GOAL) begin
         if (request_q.size() > ITEM_GOAL - 150) calm_now = 1;
         if ($urandom_range(0, 4) == 0) random_noise();
         else random_instr();
         if (++n == 300) hold_until_drained();
      end
      stop_machine();
      for (n = 0; n < 20; n++) begin
         if (n % 2) issue(1, $urandom_range(0, 16383), pick_value());
         else random_noise();
      end
   endtask

   always @(posedge clock) begin
      bit accepted;
      accepted = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (accepted) begin
            sent_count <= sent_count + 1;
            void'(request_q.pop_front());
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (request_q.size() == 0) begin
               req_valid <= 1'b0;
            end else if (request_q[0].drain) begin
               req_valid <= 1'b0;
               if (got_count == sent_count + accepted) void'(request_q.pop_front());
            end else if (!request_q[0].calm && $urandom_range(0, 15) == 0) begin
               send_gap <= $urandom_range(1, 16);
               req_valid <= 1'b0;
            end else begin
               if (request_q[0].calm) quiet <= 1'b1;
               req_valid <= 1'b1;
               req_operation <= request_q[0].operation;
               req_address <= request_q[0].address;
               req_data_word <= request_q[0].data_word;
            end
         end
      end
   end

   always @(posedge clock) begin
      response_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_count <= got_count + 1;
            if (response_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response status=%0d", rsp_status);
            end else begin
               want = response_q.pop_front();
               if (rsp_status !== want.status || rsp_out_valid !== want.out_valid ||
                   rsp_out_address !== want.out_address ||
                   rsp_out_value !== want.out_value ||
                   rsp_program_count !== want.program_count ||
                   rsp_accumulator_value !== want.accumulator_value) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"response %0d: expected st=%0d ov=%0d oa=%0d val=%0d",
                               " pc=%0d acc=%0d, got st=%0d ov=%0d oa=%0d val=%0d",
                               " pc=%0d acc=%0d"},
                              got_count, want.status, want.out_valid, want.out_address,
                              want.out_value, want.program_count, want.accumulator_value,
                              rsp_status, rsp_out_valid, rsp_out_address, rsp_out_value,
                              rsp_program_count, rsp_accumulator_value);
               end
            end
         end
         if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            rsp_ready <= 1'b0;
         end else if (got_count == 300 && !long_done) begin
            long_done <= 1'b1;
            long_hold <= 400;
            rsp_ready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            take_gap <= $urandom_range(1, 16);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_MAX) begin
         $display("decimal_accumulator_machine_test NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      build_stimulus();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (request_q.size() != 0 || got_count != sent_count) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0 && response_q.size() == 0) begin
         $display("decimal_accumulator_machine_test OK");
      end else begin
         $display("decimal_accumulator_machine_test NOT OK");
      end
      $finish;
   end

endmodule
